>>> design/nccn_pkg.sv
package nccn_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int MAX_AXES    = 6;

	localparam int IDX_W   = $clog2(MAX_ENTRIES);
	localparam int CNT_W   = IDX_W + 1;
	localparam int AX_W    = $clog2(MAX_AXES);
	localparam int REF_W   = 8;
	localparam int COORD_W = 16;
	localparam int SCALE_W = 16;
	localparam int AXES_W  = 3;
	localparam int WORD_W  = COORD_W * MAX_AXES;

	// q4.12 scaling
	localparam int SCALE_SHIFT = 12;
	localparam int SCALE_ONE   = 4096;
	localparam int PROD_W      = COORD_W + SCALE_W + 1;
	localparam int SH_W        = PROD_W - SCALE_SHIFT;

	// distance arithmetic
	localparam int SQ_W   = 2 * COORD_W;
	localparam int PAIRS  = (MAX_AXES + 1) / 2;
	localparam int PAIR_W = SQ_W + 1;
	localparam int DIST_W = 35;

	// stream layout
	localparam int IN_DATA_W  = REF_W + WORD_W;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_PAD_W  = OUT_DATA_W - IDX_W - DIST_W;
	localparam int OUT_USER_W = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_AXES       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_BASE = 3'd1;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_LINKED = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_BAD_REF = 2'd2,
		STAT_NONE    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RES_INSERT,
		RES_FULL,
		RES_BAD_REF,
		RES_QUERY,
		RES_EMPTY
	} res_sel_t;

	typedef struct packed {
		logic            load;
		logic            scale_en;
		logic [AX_W-1:0] axis;
		logic            write_entry;
		logic            scan_clear;
		logic            scan_issue;
		logic [IDX_W-1:0] scan_addr;
		logic            res_load;
		res_sel_t        res_sel;
	} cmd_t;

	typedef struct packed {
		kind_t            kind;
		logic             full;
		logic             bad_ref;
		logic             empty;
		logic [IDX_W-1:0] last_idx;
		logic             pipe_busy;
		logic             out_free;
	} stat_t;

endpackage

>>> design/nccn_ctrl.sv
module nccn_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  nccn_pkg::stat_t stat,
	output nccn_pkg::cmd_t  cmd
);
	import nccn_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCALE,
		ST_SETTLE,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [AX_W-1:0]  axis_q;
	logic [IDX_W-1:0] scan_q;
	res_sel_t         res_sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			axis_q    <= '0;
			scan_q    <= '0;
			res_sel_q <= RES_EMPTY;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					unique case (stat.kind)
						KIND_INSERT, KIND_LINKED: begin
							if (stat.full) begin
								res_sel_q <= RES_FULL;
								state_q   <= ST_FINISH;
							end else if (stat.bad_ref) begin
								res_sel_q <= RES_BAD_REF;
								state_q   <= ST_FINISH;
							end else begin
								axis_q  <= '0;
								state_q <= ST_SCALE;
							end
						end
						KIND_QUERY: begin
							scan_q  <= '0;
							state_q <= stat.empty ? ST_DRAIN : ST_SCAN;
						end
						KIND_UNUSED: begin
							res_sel_q <= RES_EMPTY;
							state_q   <= ST_FINISH;
						end
					endcase
				end
				ST_SCALE: begin
					if (axis_q == AX_W'(MAX_AXES - 1)) state_q <= ST_SETTLE;
					else axis_q <= axis_q + 1'b1;
				end
				ST_SETTLE: begin
					res_sel_q <= RES_INSERT;
					state_q   <= ST_WRITE;
				end
				ST_WRITE: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_q == stat.last_idx) state_q <= ST_DRAIN;
					else scan_q <= scan_q + 1'b1;
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy) begin
						res_sel_q <= RES_QUERY;
						state_q   <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.load        = s_tready && s_tvalid;
		cmd.axis        = axis_q;
		cmd.scale_en    = (state_q == ST_SCALE);
		cmd.scan_clear  = (state_q == ST_DISPATCH);
		cmd.scan_issue  = (state_q == ST_SCAN);
		cmd.scan_addr   = scan_q;
		cmd.write_entry = (state_q == ST_WRITE) && stat.out_free;
		cmd.res_load    = ((state_q == ST_WRITE) || (state_q == ST_FINISH)) && stat.out_free;
		cmd.res_sel     = res_sel_q;
	end

endmodule

>>> design/nccn_dpath.sv
module nccn_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nccn_pkg::cmd_t                     cmd,
	output nccn_pkg::stat_t                    stat,
	input  logic [nccn_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [nccn_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [nccn_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [nccn_pkg::OUT_USER_W-1:0]    m_tuser,
	input  logic                               cfg_valid,
	input  logic [nccn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nccn_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import nccn_pkg::*;

	// item register
	kind_t                     kind_q;
	logic                      back_q;
	logic [REF_W-1:0]          ref_q;
	logic signed [COORD_W-1:0] joint_q [MAX_AXES];

	// configuration
	logic [AXES_W-1:0]  axes_q;
	logic [SCALE_W-1:0] scale_q [MAX_AXES];
	logic [AXES_W-1:0]  axes_eff;
	logic [MAX_AXES-1:0] axis_on;

	// table state
	logic [WORD_W-1:0]      mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] pflag_q;
	logic [MAX_ENTRIES-1:0] cflag_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_m1;
	logic [IDX_W-1:0]       wr_idx;

	// scaling unit
	logic signed [PROD_W-1:0]  prod_s1;
	logic [AX_W-1:0]           prod_ax_s1;
	logic                      prod_vld_s1;
	logic signed [SH_W-1:0]    shifted;
	logic signed [COORD_W-1:0] sat_c;
	logic signed [COORD_W-1:0] scaled_q [MAX_AXES];
	logic [WORD_W-1:0]         wr_word;

	// scan pipeline
	logic                      v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]          idx_s1, idx_s2, idx_s3, idx_s4;
	logic [WORD_W-1:0]         rd_s1;
	logic signed [COORD_W:0]   diff_c [MAX_AXES];
	logic signed [COORD_W:0]   neg_c [MAX_AXES];
	logic [COORD_W-1:0]        mag_c [MAX_AXES];
	logic [SQ_W-1:0]           sq_c [MAX_AXES];
	logic [SQ_W-1:0]           sq_s2 [2*PAIRS];
	logic [PAIR_W-1:0]         pair_s3 [PAIRS];
	logic [DIST_W-1:0]         sum_c;
	logic [DIST_W-1:0]         dist_s4;
	logic                      found_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic [DIST_W-1:0]         best_d_q;

	// output register
	logic              out_vld_q;
	status_t           out_stat_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [DIST_W-1:0] out_dist_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(s_tuser[1:0]);
			back_q <= s_tuser[2];
			ref_q  <= s_tdata[REF_W-1:0];
			for (int a = 0; a < MAX_AXES; a++) begin
				joint_q[a] <= s_tdata[REF_W + COORD_W*a +: COORD_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axes_q <= AXES_W'(MAX_AXES);
			for (int a = 0; a < MAX_AXES; a++) scale_q[a] <= SCALE_W'(SCALE_ONE);
		end else if (cfg_valid) begin
			if (cfg_index == REG_AXES) axes_q <= cfg_data[AXES_W-1:0];
			for (int a = 0; a < MAX_AXES; a++) begin
				if (cfg_index == REG_SCALE_BASE + CFG_IDX_W'(a)) scale_q[a] <= cfg_data;
			end
		end
	end

	always_comb begin
		axes_eff = (axes_q > AXES_W'(MAX_AXES)) ? AXES_W'(MAX_AXES) : axes_q;
		for (int a = 0; a < MAX_AXES; a++) axis_on[a] = (AXES_W'(a) < axes_eff);
	end

	// one axis per cycle through the shared multiplier
	always_ff @(posedge clk) begin
		prod_s1    <= joint_q[cmd.axis] * $signed({1'b0, scale_q[cmd.axis]});
		prod_ax_s1 <= cmd.axis;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prod_vld_s1 <= 1'b0;
		else prod_vld_s1 <= cmd.scale_en;
	end

	// floor shift, then saturate to the coordinate range
	always_comb begin
		shifted = prod_s1[PROD_W-1:SCALE_SHIFT];
		if (shifted > $signed(SH_W'(2**(COORD_W-1) - 1)))
			sat_c = {1'b0, {(COORD_W-1){1'b1}}};
		else if (shifted < -$signed(SH_W'(2**(COORD_W-1))))
			sat_c = {1'b1, {(COORD_W-1){1'b0}}};
		else
			sat_c = shifted[COORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (prod_vld_s1) scaled_q[prod_ax_s1] <= sat_c;
	end

	always_comb begin
		for (int a = 0; a < MAX_AXES; a++) wr_word[COORD_W*a +: COORD_W] = scaled_q[a];
	end

	assign wr_idx   = count_q[IDX_W-1:0];
	assign count_m1 = count_q - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.write_entry) mem[wr_idx] <= wr_word;
		rd_s1 <= mem[cmd.scan_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pflag_q <= '0;
			cflag_q <= '0;
			count_q <= '0;
		end else if (cmd.write_entry) begin
			pflag_q[wr_idx] <= (kind_q == KIND_LINKED) && !back_q;
			cflag_q[wr_idx] <= (kind_q == KIND_LINKED) && back_q;
			if (kind_q == KIND_LINKED) begin
				if (back_q) pflag_q[ref_q] <= 1'b1;
				else cflag_q[ref_q] <= 1'b1;
			end
			count_q <= count_q + 1'b1;
		end
	end

	// distance lanes
	always_comb begin
		for (int a = 0; a < MAX_AXES; a++) begin
			diff_c[a] = {joint_q[a][COORD_W-1], joint_q[a]}
				- $signed({rd_s1[COORD_W*a + COORD_W-1], rd_s1[COORD_W*a +: COORD_W]});
			neg_c[a]  = -diff_c[a];
			mag_c[a]  = diff_c[a][COORD_W] ? neg_c[a][COORD_W-1:0] : diff_c[a][COORD_W-1:0];
			sq_c[a]   = mag_c[a] * mag_c[a];
		end
		sum_c = '0;
		for (int p = 0; p < PAIRS; p++) sum_c = sum_c + DIST_W'(pair_s3[p]);
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.scan_addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		for (int a = 0; a < 2*PAIRS; a++)
			sq_s2[a] <= ((a < MAX_AXES) && axis_on[a]) ? sq_c[a] : '0;
		for (int p = 0; p < PAIRS; p++)
			pair_s3[p] <= PAIR_W'(sq_s2[2*p]) + PAIR_W'(sq_s2[2*p+1]);
		dist_s4 <= sum_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue && pflag_q[cmd.scan_addr] && cflag_q[cmd.scan_addr];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// strict less keeps the first of equal distances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_clear) begin
			found_q <= 1'b0;
		end else if (v_s4 && (!found_q || dist_s4 < best_d_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.scan_clear && v_s4 && (!found_q || dist_s4 < best_d_q)) begin
			best_idx_q <= idx_s4;
			best_d_q   <= dist_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (cmd.res_load) out_vld_q <= 1'b1;
		else if (m_tready) out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_idx_q  <= '0;
			out_dist_q <= '0;
			unique case (cmd.res_sel)
				RES_INSERT: begin
					out_stat_q <= STAT_OK;
					out_idx_q  <= wr_idx;
				end
				RES_FULL:    out_stat_q <= STAT_FULL;
				RES_BAD_REF: out_stat_q <= STAT_BAD_REF;
				RES_QUERY: begin
					if (found_q) begin
						out_stat_q <= STAT_OK;
						out_idx_q  <= best_idx_q;
						out_dist_q <= best_d_q;
					end else begin
						out_stat_q <= STAT_NONE;
					end
				end
				RES_EMPTY:   out_stat_q <= STAT_OK;
				default:     out_stat_q <= STAT_OK;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_dist_q, out_idx_q};
	assign m_tuser  = out_stat_q;

	always_comb begin
		stat.kind      = kind_q;
		stat.full      = (count_q == CNT_W'(MAX_ENTRIES));
		stat.bad_ref   = (kind_q == KIND_LINKED) && (CNT_W'(ref_q) >= count_q);
		stat.empty     = (count_q == '0);
		stat.last_idx  = count_m1[IDX_W-1:0];
		stat.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
		stat.out_free  = !out_vld_q || m_tready;
	end

endmodule

>>> design/nearest_connected_node_table_core.sv
// insert: the 6 axes are scaled in turn on one shared multiplier, then the entry is written
// query: one entry read per cycle, an empty table skips the scan
// rejects and unused kinds go straight to the result; a full table query is the longest item
// throughput: one word at a time, the next word is taken the cycle after its result is
//   loaded into the output register, which may still be waiting for m_tready
// reset: table empty, link flags cleared, axes 6, all scales 1.0, no memory clearing pass
module nearest_connected_node_table_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// input words
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// ref_index, joint_0, joint_1, joint_2, joint_3, joint_4, joint_5
	input  logic [nccn_pkg::IN_DATA_W-1:0]     s_tdata,
	// kind, link_backward
	input  logic [nccn_pkg::IN_USER_W-1:0]     s_tuser,
	// result words
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// entry_index, square_distance, zero pad
	output logic [nccn_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status
	output logic [nccn_pkg::OUT_USER_W-1:0]    m_tuser,
	// register writes, index 0 axes_in_use, 1 to 6 scale_axis0 to scale_axis5
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nccn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nccn_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import nccn_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// registers are written whenever offered; writes must only come while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	// sequencer: dispatch, per-axis scaling, table write, scan and result hand-off
	nccn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// item register, scaler, point memory, link flags, distance pipeline, output register
	nccn_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// a result never overwrites one that is still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> stat.out_free)
		else $error("result loaded over a pending word");

	// a table write only follows a passed full and reference check
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_entry |-> (!stat.full && !stat.bad_ref))
		else $error("entry written into full table or with bad reference");

	// scan addresses only exist for a non-empty table
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue |-> !stat.empty)
		else $error("scan issued on empty table");

	// one word in flight: accepting a word closes the input for the next cycle
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted while busy");

endmodule
